// File: src/gas_pkg.sv
package gas_pkg;

    // Field widths of the words on both channels and of the register.
    localparam int OP_W       = 2;
    localparam int COL_FLD_W  = 2;
    localparam int ROW_FLD_W  = 2;
    localparam int DRAWS_W    = 8;
    localparam int DRAW_W     = 2;
    localparam int DRAW_SLOTS = 4;
    localparam int POT_W      = 10;
    localparam int CNT_OUT_W  = 3;

    // Internal widths.
    localparam int MASK_W  = 4;
    localparam int TICK_W  = 7;
    localparam int SPEED_W = 5;

    // Tempo: the step limit is ((pot >> POT_SHIFT) + 1) * STEP_MUL.
    localparam int POT_SHIFT = 6;
    localparam int STEP_MUL  = 5;

    // A press on the held row only changes the order with at least this many active columns.
    localparam int MIN_PICK_ACTIVE = 3;

    localparam int COLUMNS_DEF = 4;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_PRESS = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Which column the single grid read port looks at.
    typedef enum logic [1:0] {
        RD_ITEM    = 2'd0,
        RD_SKIP    = 2'd1,
        RD_CURRENT = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    load_item;
        logic    press_write;
        logic    load_asc;
        logic    load_desc;
        logic    probe_init;
        logic    probe_step;
        logic    tick_update;
        logic    skip_step;
        logic    clear_all;
        logic    load_out;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            col_valid;
        logic            held_eq;
        logic            can_pick;
        logic            pick_asc;
        logic            pick_desc;
        logic            any_active;
        logic            tick_over;
        logic            probe_done;
        logic            skip_hit;
        logic            out_free;
    } status_t;

endpackage

// File: src/grid_arpeggiator_sequencer.sv
// Grid arpeggiator sequencer: a COLUMNS by four button grid in which each column holds at most
// one note. Each input word is a tempo tick, a button press or a clear, and every word yields
// exactly one result word giving whether the tick stepped, the sounding column, its row and the
// number of active columns. A word passes through accept, decode and result, plus the extra
// work it causes: a tick that steps tries the columns in the play order one at a time, from one
// to COLUMNS of them, and a random order pick probes the used-value set once per value tried,
// COLUMNS settles plus at most COLUMNS*(COLUMNS-1)/2 collisions. The grid has a single read
// port, and the probing and skipping are done one step per cycle. The tempo register may be
// written at any time but is only sampled when a tick is decoded; write it while the block is
// idle. No clearing pass is needed after reset.
module grid_arpeggiator_sequencer #(
    parameter int COLUMNS = gas_pkg::COLUMNS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Tempo register write port.
    input  logic                           cfg_wr_en,
    input  logic [gas_pkg::POT_W-1:0]      cfg_wr_data,
    // Input words.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [gas_pkg::OP_W-1:0]       s_operation,
    input  logic [gas_pkg::COL_FLD_W-1:0]  s_column,
    input  logic [gas_pkg::ROW_FLD_W-1:0]  s_row,
    input  logic [gas_pkg::DRAWS_W-1:0]    s_random_draws,
    // Result words.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_stepped,
    output logic [gas_pkg::COL_FLD_W-1:0]  m_note_column,
    output logic [gas_pkg::ROW_FLD_W-1:0]  m_note_row,
    output logic [gas_pkg::CNT_OUT_W-1:0]  m_active_count
);

    // The controller sequences each word; the datapath holds the grid, the play order, the
    // tempo counter and the result register, and reports the conditions the controller branches
    // on. The result register lets a new word be accepted while the previous result still waits.
    gas_pkg::cmd_t    cmd;
    gas_pkg::status_t status;

    gas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gas_dpath #(
        .COLUMNS (COLUMNS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_operation    (s_operation),
        .s_column       (s_column),
        .s_row          (s_row),
        .s_random_draws (s_random_draws),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_stepped      (m_stepped),
        .m_note_column  (m_note_column),
        .m_note_row     (m_note_row),
        .m_active_count (m_active_count),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

// File: src/gas_ctrl.sv
module gas_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  gas_pkg::status_t status,
    output gas_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_PROBE  = 5'b00100,
        ST_SKIP   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = gas_pkg::RD_ITEM;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_FINISH;
                case (status.op)
                    gas_pkg::OP_TICK: begin
                        if (status.any_active) begin
                            cmd.tick_update = 1'b1;
                            if (status.tick_over) begin
                                state_next = ST_SKIP;
                            end
                        end
                    end
                    gas_pkg::OP_PRESS: begin
                        if (status.col_valid) begin
                            if (!status.held_eq) begin
                                cmd.press_write = 1'b1;
                            end else if (status.can_pick) begin
                                if (status.pick_asc) begin
                                    cmd.load_asc = 1'b1;
                                end else if (status.pick_desc) begin
                                    cmd.load_desc = 1'b1;
                                end else begin
                                    cmd.probe_init = 1'b1;
                                    state_next     = ST_PROBE;
                                end
                            end
                        end
                    end
                    gas_pkg::OP_CLEAR: begin
                        cmd.clear_all = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_PROBE: begin
                cmd.probe_step = 1'b1;
                if (status.probe_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_SKIP: begin
                cmd.rd_sel    = gas_pkg::RD_SKIP;
                cmd.skip_step = 1'b1;
                if (status.skip_hit) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.rd_sel = gas_pkg::RD_CURRENT;
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/gas_dpath.sv
module gas_dpath #(
    parameter int COLUMNS = gas_pkg::COLUMNS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gas_pkg::POT_W-1:0]           cfg_wr_data,
    input  logic [gas_pkg::OP_W-1:0]            s_operation,
    input  logic [gas_pkg::COL_FLD_W-1:0]       s_column,
    input  logic [gas_pkg::ROW_FLD_W-1:0]       s_row,
    input  logic [gas_pkg::DRAWS_W-1:0]         s_random_draws,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_stepped,
    output logic [gas_pkg::COL_FLD_W-1:0]       m_note_column,
    output logic [gas_pkg::ROW_FLD_W-1:0]       m_note_row,
    output logic [gas_pkg::CNT_OUT_W-1:0]       m_active_count,
    input  gas_pkg::cmd_t                       cmd,
    output gas_pkg::status_t                    status
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int CNT_W = $clog2(COLUMNS + 1);
    localparam int MW    = gas_pkg::MASK_W;
    localparam int TW    = gas_pkg::TICK_W;

    // Architectural state.
    logic [MW-1:0]            rows_reg  [COLUMNS];
    logic [MW-1:0]            rows_next [COLUMNS];
    logic [CW-1:0]            order_reg [COLUMNS];
    logic [CW-1:0]            order_next[COLUMNS];
    logic [CW-1:0]            pos_reg, pos_next;
    logic [CW-1:0]            cur_reg, cur_next;
    logic [TW-1:0]            tick_reg, tick_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [gas_pkg::POT_W-1:0] pot_reg, pot_next;
    logic                     out_valid_reg, out_valid_next;

    // Latched word and working registers.
    logic [gas_pkg::OP_W-1:0]      op_reg, op_next;
    logic [gas_pkg::COL_FLD_W-1:0] col_reg, col_next;
    logic [gas_pkg::ROW_FLD_W-1:0] row_reg, row_next;
    logic [gas_pkg::DRAWS_W-1:0]   draws_reg, draws_next;
    logic                          stepped_reg, stepped_next;
    logic [CW-1:0]                 slot_reg, slot_next;
    logic [CW-1:0]                 cand_reg, cand_next;
    logic [COLUMNS-1:0]            used_reg, used_next;

    // Result payload.
    logic                              o_stepped_reg, o_stepped_next;
    logic [gas_pkg::COL_FLD_W-1:0]     o_col_reg, o_col_next;
    logic [gas_pkg::ROW_FLD_W-1:0]     o_row_reg, o_row_next;
    logic [gas_pkg::CNT_OUT_W-1:0]     o_cnt_reg, o_cnt_next;

    logic [CW-1:0]   col_idx;
    logic [CW-1:0]   pos_inc;
    logic [CW-1:0]   order_rd;
    logic [CW-1:0]   rd_addr;
    logic [MW-1:0]   rows_rd;
    logic [MW-1:0]   want;
    logic [MW-1:0]   moved;
    logic [CW-1:0]   slot_inc;
    logic [CW-1:0]   cand_inc;
    logic [CW-1:0]   draw_first;
    logic [CW-1:0]   draw_after;
    logic [gas_pkg::SPEED_W-1:0] speed;
    logic [TW-1:0]   limit;
    logic [gas_pkg::ROW_FLD_W-1:0] note_row;

    // One draw reduced to a column number; two-bit values need one subtraction at most.
    function automatic logic [CW-1:0] draw_of(input logic [gas_pkg::DRAWS_W-1:0] d,
                                               input logic [CW-1:0] slot);
        logic [gas_pkg::DRAW_W-1:0] raw;
        logic [CW-1:0]              res;
        res = '0;
        for (int j = 0; j < gas_pkg::DRAW_SLOTS; j++) begin
            raw = d[gas_pkg::DRAW_W*j +: gas_pkg::DRAW_W];
            if (32'(slot) == j) begin
                if (32'(raw) >= COLUMNS) begin
                    res = CW'(32'(raw) - COLUMNS);
                end else begin
                    res = CW'(raw);
                end
            end
        end
        return res;
    endfunction

    function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] v);
        if (32'(v) == COLUMNS - 1) begin
            return '0;
        end
        return v + 1'b1;
    endfunction

    assign col_idx  = CW'(col_reg);
    assign pos_inc  = wrap_inc(pos_reg);
    assign cand_inc = wrap_inc(cand_reg);
    assign slot_inc = slot_reg + 1'b1;

    always_comb begin
        order_rd = '0;
        for (int j = 0; j < COLUMNS; j++) begin
            if (32'(pos_inc) == j) begin
                order_rd = order_reg[j];
            end
        end
    end

    always_comb begin
        case (cmd.rd_sel)
            gas_pkg::RD_ITEM:    rd_addr = col_idx;
            gas_pkg::RD_SKIP:    rd_addr = order_rd;
            gas_pkg::RD_CURRENT: rd_addr = cur_reg;
            default:             rd_addr = col_idx;
        endcase
    end

    always_comb begin
        rows_rd = '0;
        for (int j = 0; j < COLUMNS; j++) begin
            if (32'(rd_addr) == j) begin
                rows_rd = rows_reg[j];
            end
        end
    end

    assign want  = MW'(4'b1000) >> row_reg;
    assign moved = (want > rows_rd) ? {rows_rd[MW-2:0], 1'b0} : (rows_rd >> 1);

    assign draw_first = draw_of(draws_reg, '0);
    assign draw_after = draw_of(draws_reg, slot_inc);

    assign speed = gas_pkg::SPEED_W'(pot_reg[gas_pkg::POT_W-1:gas_pkg::POT_SHIFT]) + 1'b1;
    assign limit = TW'(speed) * TW'(gas_pkg::STEP_MUL);

    always_comb begin
        if (rows_rd[3]) begin
            note_row = 2'd0;
        end else if (rows_rd[2]) begin
            note_row = 2'd1;
        end else if (rows_rd[1]) begin
            note_row = 2'd2;
        end else if (rows_rd[0]) begin
            note_row = 2'd3;
        end else begin
            note_row = 2'd0;
        end
    end

    always_comb begin
        status            = '0;
        status.op         = op_reg;
        status.col_valid  = (32'(col_reg) < COLUMNS);
        status.held_eq    = (rows_rd == want);
        status.can_pick   = (32'(cnt_reg) >= gas_pkg::MIN_PICK_ACTIVE);
        status.pick_asc   = (32'(col_reg) == 0) ||
                            ((32'(col_reg) == 1) && (rows_reg[0] == '0));
        status.pick_desc  = (32'(col_reg) == COLUMNS - 1) ||
                            ((32'(col_reg) == COLUMNS - 2) && (rows_reg[COLUMNS-1] == '0));
        status.any_active = (cnt_reg != '0);
        status.tick_over  = (tick_reg > limit);
        status.probe_done = !used_reg[cand_reg] && (32'(slot_reg) == COLUMNS - 1);
        status.skip_hit   = (rows_rd != '0);
        status.out_free   = !out_valid_reg || m_ready;
    end

    always_comb begin
        rows_next      = rows_reg;
        order_next     = order_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        tick_next      = tick_reg;
        cnt_next       = cnt_reg;
        pot_next       = pot_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        draws_next     = draws_reg;
        stepped_next   = stepped_reg;
        slot_next      = slot_reg;
        cand_next      = cand_reg;
        used_next      = used_reg;
        o_stepped_next = o_stepped_reg;
        o_col_next     = o_col_reg;
        o_row_next     = o_row_reg;
        o_cnt_next     = o_cnt_reg;

        if (cfg_wr_en) begin
            pot_next = cfg_wr_data;
        end

        if (cmd.load_item) begin
            op_next      = s_operation;
            col_next     = s_column;
            row_next     = s_row;
            draws_next   = s_random_draws;
            stepped_next = 1'b0;
        end

        if (cmd.press_write) begin
            for (int j = 0; j < COLUMNS; j++) begin
                if (32'(col_idx) == j) begin
                    rows_next[j] = (rows_rd == '0) ? want : moved;
                end
            end
            if (rows_rd == '0) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end

        if (cmd.load_asc) begin
            for (int j = 0; j < COLUMNS; j++) begin
                order_next[j] = CW'(j);
            end
        end

        if (cmd.load_desc) begin
            for (int j = 0; j < COLUMNS; j++) begin
                order_next[j] = CW'(COLUMNS - 1 - j);
            end
        end

        if (cmd.probe_init) begin
            slot_next = '0;
            used_next = '0;
            cand_next = draw_first;
        end

        // Either probe the next value or settle the slot on a free one.
        if (cmd.probe_step) begin
            if (used_reg[cand_reg]) begin
                cand_next = cand_inc;
            end else begin
                for (int j = 0; j < COLUMNS; j++) begin
                    if (32'(slot_reg) == j) begin
                        order_next[j] = cand_reg;
                    end
                end
                used_next[cand_reg] = 1'b1;
                slot_next           = slot_inc;
                cand_next           = (32'(slot_inc) < gas_pkg::DRAW_SLOTS) ? draw_after : '0;
            end
        end

        if (cmd.tick_update) begin
            if (tick_reg > limit) begin
                tick_next    = '0;
                stepped_next = 1'b1;
            end else begin
                tick_next = tick_reg + 1'b1;
            end
        end

        if (cmd.skip_step) begin
            pos_next = pos_inc;
            cur_next = order_rd;
        end

        if (cmd.clear_all) begin
            for (int j = 0; j < COLUMNS; j++) begin
                rows_next[j]  = '0;
                order_next[j] = CW'(j);
            end
            pos_next = '0;
            cur_next = '0;
            cnt_next = '0;
        end

        if (cmd.load_out) begin
            out_valid_next = 1'b1;
            o_stepped_next = stepped_reg;
            o_col_next     = gas_pkg::COL_FLD_W'(cur_reg);
            o_row_next     = note_row;
            o_cnt_next     = gas_pkg::CNT_OUT_W'(cnt_reg);
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < COLUMNS; j++) begin
                rows_reg[j]  <= '0;
                order_reg[j] <= CW'(j);
            end
            pos_reg       <= '0;
            cur_reg       <= '0;
            tick_reg      <= '0;
            cnt_reg       <= '0;
            pot_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            rows_reg      <= rows_next;
            order_reg     <= order_next;
            pos_reg       <= pos_next;
            cur_reg       <= cur_next;
            tick_reg      <= tick_next;
            cnt_reg       <= cnt_next;
            pot_reg       <= pot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        draws_reg     <= draws_next;
        stepped_reg   <= stepped_next;
        slot_reg      <= slot_next;
        cand_reg      <= cand_next;
        used_reg      <= used_next;
        o_stepped_reg <= o_stepped_next;
        o_col_reg     <= o_col_next;
        o_row_reg     <= o_row_next;
        o_cnt_reg     <= o_cnt_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_stepped      = o_stepped_reg;
    assign m_note_column  = o_col_reg;
    assign m_note_row     = o_row_reg;
    assign m_active_count = o_cnt_reg;

endmodule

// File: src/gas_checker.sv
module gas_checker #(
    parameter int COLUMNS = gas_pkg::COLUMNS_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_stepped,
    input logic [gas_pkg::COL_FLD_W-1:0]  m_note_column,
    input logic [gas_pkg::ROW_FLD_W-1:0]  m_note_row,
    input logic [gas_pkg::CNT_OUT_W-1:0]  m_active_count
);

    // A result word is held until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped before it was taken");

    // One word is worked on at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is in progress");

    a_column_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_note_column) < COLUMNS))
        else $error("sounding column outside the grid");

    // A step is only reported while some column holds a note.
    a_step_needs_note: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stepped |-> m_active_count != '0)
        else $error("step reported with no active column");

    a_empty_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_active_count == '0) |-> (m_note_row == '0) && !m_stepped)
        else $error("empty grid reports a note");

endmodule

bind grid_arpeggiator_sequencer gas_checker #(.COLUMNS(COLUMNS)) u_gas_checker (.*);

// File: bench/gas_checker.sv
module gas_scoreboard (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gas_pkg::POT_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [gas_pkg::OP_W-1:0]      s_operation,
    input  logic [gas_pkg::COL_FLD_W-1:0] s_column,
    input  logic [gas_pkg::ROW_FLD_W-1:0] s_row,
    input  logic [gas_pkg::DRAWS_W-1:0]   s_random_draws,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_stepped,
    input  logic [gas_pkg::COL_FLD_W-1:0] m_note_column,
    input  logic [gas_pkg::ROW_FLD_W-1:0] m_note_row,
    input  logic [gas_pkg::CNT_OUT_W-1:0] m_active_count,
    output int                            errors,
    output int                            awaited,
    output int                            words_checked,
    output int                            steps_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOL = gas_pkg::COLUMNS_DEF;

    typedef struct packed {
        logic                          stepped;
        logic [gas_pkg::COL_FLD_W-1:0] note_column;
        logic [gas_pkg::ROW_FLD_W-1:0] note_row;
        logic [gas_pkg::CNT_OUT_W-1:0] active_count;
    } note_report_t;

    // Shadow of the grid, the play order and the tempo counter.
    logic [gas_pkg::MASK_W-1:0]    rows_held [NCOL];
    logic [gas_pkg::COL_FLD_W-1:0] play_seq [NCOL];
    logic [gas_pkg::COL_FLD_W-1:0] seq_pos;
    logic [gas_pkg::COL_FLD_W-1:0] now_col;
    logic [gas_pkg::TICK_W-1:0]    tick_cnt;
    logic [gas_pkg::POT_W-1:0]     tempo;

    note_report_t reports_due [$];
    note_report_t due;

    initial begin
        errors        = 0;
        awaited       = 0;
        words_checked = 0;
        steps_seen    = 0;
    end

    function automatic int active_columns();
        int n;
        n = 0;
        for (int i = 0; i < NCOL; i++) begin
            if (rows_held[i] != '0) n++;
        end
        return n;
    endfunction

    function automatic void clear_grid();
        for (int i = 0; i < NCOL; i++) begin
            rows_held[i] = '0;
            play_seq[i]  = gas_pkg::COL_FLD_W'(i);
        end
        seq_pos = '0;
        now_col = '0;
    endfunction

    // Ascending or descending by the pressed column, otherwise a permutation built from the
    // draws, each slot probing upwards past values already taken.
    function automatic void choose_order(input logic [gas_pkg::COL_FLD_W-1:0] col,
                                         input logic [gas_pkg::DRAWS_W-1:0] draws);
        logic                          taken [NCOL];
        logic [gas_pkg::COL_FLD_W-1:0] fresh [NCOL];
        logic [gas_pkg::COL_FLD_W-1:0] v;
        if (col == 0 || (col == 1 && rows_held[0] == '0)) begin
            for (int i = 0; i < NCOL; i++) play_seq[i] = gas_pkg::COL_FLD_W'(i);
        end else if (col == NCOL - 1 || (col == NCOL - 2 && rows_held[NCOL-1] == '0)) begin
            for (int i = 0; i < NCOL; i++) play_seq[i] = gas_pkg::COL_FLD_W'(NCOL - 1 - i);
        end else begin
            for (int i = 0; i < NCOL; i++) taken[i] = 1'b0;
            for (int i = 0; i < NCOL; i++) begin
                v = draws[gas_pkg::DRAW_W*i +: gas_pkg::DRAW_W];
                for (int k = 0; k < NCOL && taken[v]; k++) v = v + 1'b1;
                taken[v] = 1'b1;
                fresh[i] = v;
            end
            for (int i = 0; i < NCOL; i++) play_seq[i] = fresh[i];
        end
    endfunction

    function automatic void press_button(input logic [gas_pkg::COL_FLD_W-1:0] col,
                                         input logic [gas_pkg::ROW_FLD_W-1:0] row,
                                         input logic [gas_pkg::DRAWS_W-1:0] draws);
        logic [gas_pkg::MASK_W-1:0] want;
        logic [gas_pkg::MASK_W-1:0] held;
        want = 4'b1000 >> row;
        held = rows_held[col];
        if (held == '0) begin
            rows_held[col] = want;
        end else if (want > held) begin
            rows_held[col] = held << 1;
        end else if (want < held) begin
            rows_held[col] = held >> 1;
        end else if (active_columns() >= gas_pkg::MIN_PICK_ACTIVE) begin
            choose_order(col, draws);
        end
    endfunction

    function automatic logic advance_tempo();
        int                            limit;
        logic [gas_pkg::TICK_W-1:0]    old;
        logic [gas_pkg::COL_FLD_W-1:0] pos;
        if (active_columns() == 0) return 1'b0;
        limit    = ((int'(tempo) >> gas_pkg::POT_SHIFT) + 1) * gas_pkg::STEP_MUL;
        old      = tick_cnt;
        tick_cnt = tick_cnt + 1'b1;
        if (int'(old) <= limit) return 1'b0;
        tick_cnt = '0;
        pos      = seq_pos;
        for (int k = 0; k < NCOL; k++) begin
            pos     = pos + 1'b1;
            now_col = play_seq[pos];
            if (rows_held[now_col] != '0) break;
        end
        seq_pos = pos;
        return 1'b1;
    endfunction

    function automatic note_report_t play_word(input logic [gas_pkg::OP_W-1:0] op,
                                               input logic [gas_pkg::COL_FLD_W-1:0] col,
                                               input logic [gas_pkg::ROW_FLD_W-1:0] row,
                                               input logic [gas_pkg::DRAWS_W-1:0] draws);
        note_report_t               r;
        logic [gas_pkg::MASK_W-1:0] held;
        r = '0;
        case (op)
            gas_pkg::OP_TICK:  r.stepped = advance_tempo();
            gas_pkg::OP_PRESS: press_button(col, row, draws);
            gas_pkg::OP_CLEAR: clear_grid();
            default:  ;
        endcase
        held          = rows_held[now_col];
        r.note_column = now_col;
        if (held[3])      r.note_row = 2'd0;
        else if (held[2]) r.note_row = 2'd1;
        else if (held[1]) r.note_row = 2'd2;
        else if (held[0]) r.note_row = 2'd3;
        else              r.note_row = 2'd0;
        r.active_count = gas_pkg::CNT_OUT_W'(active_columns());
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [3:0] want,
                                          input logic [3:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            tempo    = '0;
            tick_cnt = '0;
            clear_grid();
            reports_due.delete();
        end else begin
            if (cfg_wr_en) tempo = cfg_wr_data;
            if (s_valid && s_ready) begin
                reports_due.push_back(play_word(s_operation, s_column, s_row, s_random_draws));
            end
            if (m_valid && m_ready) begin
                if (reports_due.size() == 0) begin
                    $error("Result word arrived with none expected.");
                    errors++;
                end else begin
                    due = reports_due.pop_front();
                    compare_field("stepped", due.stepped, m_stepped);
                    compare_field("note_column", due.note_column, m_note_column);
                    compare_field("note_row", due.note_row, m_note_row);
                    compare_field("active_count", due.active_count, m_active_count);
                    words_checked++;
                    if (due.stepped) steps_seen++;
                end
            end
        end
        awaited = reports_due.size();
    end

endmodule

// File: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The fourth operation code has no meaning; the block must report its state unchanged.
    localparam logic [gas_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    localparam int PHASES         = 8;
    localparam int RANDOM_WORDS   = 1000;
    // Besides the work on a word inside the block, this margin covers long runs of sender
    // idling and receiver stalls.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          cfg_wr_en      = 1'b0;
    logic [gas_pkg::POT_W-1:0]     cfg_wr_data    = '0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic [gas_pkg::OP_W-1:0]      s_operation    = gas_pkg::OP_TICK;
    logic [gas_pkg::COL_FLD_W-1:0] s_column       = '0;
    logic [gas_pkg::ROW_FLD_W-1:0] s_row          = '0;
    logic [gas_pkg::DRAWS_W-1:0]   s_random_draws = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic                          m_stepped;
    logic [gas_pkg::COL_FLD_W-1:0] m_note_column;
    logic [gas_pkg::ROW_FLD_W-1:0] m_note_row;
    logic [gas_pkg::CNT_OUT_W-1:0] m_active_count;

    int errors;
    int awaited;
    int words_checked;
    int steps_seen;

    // Percentages of cycles in which the sender holds back and the receiver refuses a word.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;
    int words_sent [4] = '{default: 0};

    always #4 aclk = ~aclk;

    grid_arpeggiator_sequencer DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_column       (s_column),
        .s_row          (s_row),
        .s_random_draws (s_random_draws),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_stepped      (m_stepped),
        .m_note_column  (m_note_column),
        .m_note_row     (m_note_row),
        .m_active_count (m_active_count)
    );

    gas_scoreboard u_scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_column       (s_column),
        .s_row          (s_row),
        .s_random_draws (s_random_draws),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_stepped      (m_stepped),
        .m_note_column  (m_note_column),
        .m_note_row     (m_note_row),
        .m_active_count (m_active_count),
        .errors         (errors),
        .awaited        (awaited),
        .words_checked  (words_checked),
        .steps_seen     (steps_seen)
    );

    // The receiver decides afresh every cycle whether it will take a result word.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // The watchdog ends the run if neither channel moves a word for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one word, after a random number of idle cycles, and returns at the edge where it
    // is accepted. Valid is only lowered when an idle cycle follows, so a word sent straight
    // after another keeps valid high with a single assignment in that time step.
    task automatic send_word(input logic [gas_pkg::OP_W-1:0] op,
                             input logic [gas_pkg::COL_FLD_W-1:0] col,
                             input logic [gas_pkg::ROW_FLD_W-1:0] row,
                             input logic [gas_pkg::DRAWS_W-1:0] draws);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_column       <= col;
        s_row          <= row;
        s_random_draws <= draws;
        do @(posedge aclk); while (!s_ready);
        words_sent[op]++;
    endtask

    // Drops valid and waits, at falling edges so the checker has settled, until every
    // expected result word has been taken. Returns at a rising edge.
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (awaited != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic set_tempo(input logic [gas_pkg::POT_W-1:0] pot);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pot;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly ticks, so that steps happen often, with plenty of presses to build up columns,
    // move notes and pick play orders, and the odd clear and unused code.
    task automatic random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            send_word(gas_pkg::OP_TICK, 2'($urandom), 2'($urandom), 8'($urandom));
        end else if (pick < 96) begin
            send_word(gas_pkg::OP_PRESS, 2'($urandom_range(3)), 2'($urandom_range(3)),
                      8'($urandom_range(255)));
        end else if (pick < 98) begin
            send_word(gas_pkg::OP_CLEAR, 2'($urandom), 2'($urandom), 8'($urandom));
        end else begin
            send_word(OP_SPARE, 2'($urandom), 2'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the fastest tempo, where a step comes every seventh tick.
        set_tempo('0);
        // A tick on an empty grid does nothing, and the unused code changes nothing.
        send_word(gas_pkg::OP_TICK, 2'd0, 2'd0, 8'h00);
        send_word(OP_SPARE, 2'd3, 2'd3, 8'hFF);
        // Place a note in column 0, move it down a row and back up again.
        send_word(gas_pkg::OP_PRESS, 2'd0, 2'd0, 8'h00);
        send_word(gas_pkg::OP_PRESS, 2'd0, 2'd3, 8'h00);
        send_word(gas_pkg::OP_PRESS, 2'd0, 2'd0, 8'h00);
        // Pressing the held row with a single active column must leave the order alone.
        send_word(gas_pkg::OP_PRESS, 2'd0, 2'd0, 8'h55);
        send_word(gas_pkg::OP_PRESS, 2'd2, 2'd3, 8'h00);
        send_word(gas_pkg::OP_PRESS, 2'd3, 2'd2, 8'hFF);
        // Three active columns: the last column picks descending order, then column 2 with
        // column 3 occupied draws a random order in which every slot after the first collides.
        send_word(gas_pkg::OP_PRESS, 2'd3, 2'd2, 8'h00);
        send_word(gas_pkg::OP_PRESS, 2'd2, 2'd3, 8'hFF);
        send_word(gas_pkg::OP_PRESS, 2'd1, 2'd1, 8'h00);
        // Column 1 with column 0 occupied is random too, here with all draws zero.
        send_word(gas_pkg::OP_PRESS, 2'd1, 2'd1, 8'h00);
        send_word(gas_pkg::OP_PRESS, 2'd0, 2'd0, 8'hAA);
        repeat (7) send_word(gas_pkg::OP_TICK, 2'd3, 2'd3, 8'hFF);
        // After a clear the current column is empty, so the row reads as zero.
        send_word(gas_pkg::OP_CLEAR, 2'd1, 2'd2, 8'h0F);
        send_word(gas_pkg::OP_PRESS, 2'd2, 2'd1, 8'hF0);
        drain();

        // Random part, walking through the idling patterns and a range of tempo settings
        // including both ends of the knob.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       set_tempo(10'd1023);
                1:       set_tempo(10'd63);
                2:       set_tempo(10'd64);
                3:       set_tempo(10'($urandom_range(1023)));
                4:       set_tempo(10'd0);
                5:       set_tempo(10'($urandom_range(255)));
                6:       set_tempo(10'd1023);
                default: set_tempo(10'($urandom_range(127)));
            endcase
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 72;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 72;
                end
                default: begin
                    send_idle_pct = 31;
                    stall_pct     = 31;
                end
            endcase
            repeat (RANDOM_WORDS / PHASES) random_word();
            drain();
        end

        // Give any stray result word time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d ticks, %0d presses, %0d clears and %0d unused-code words.",
                 words_sent[gas_pkg::OP_TICK], words_sent[gas_pkg::OP_PRESS],
                 words_sent[gas_pkg::OP_CLEAR], words_sent[OP_SPARE]);
        $display("Checked %0d result words, %0d of them note steps, over %0d phases.",
                 words_checked, steps_seen, PHASES + 1);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
